@@ design/exptok_pkg.sv @@
// ----------------------------------------------------------------------------
// exptok_pkg: shared types and constants of the expression tokenizer
// Token kind codes, character classes, the queue entry format and keyword
// tables used by the front classifier and the back lexer.
// ----------------------------------------------------------------------------
package exptok_pkg;

  localparam int MANTISSA_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int KIND_W   = 5;
  localparam int PLACES_W = 4;
  localparam int NUM_KW   = 6;

  localparam logic [KIND_W-1:0] KIND_NUM   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_EQ    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_TRUE  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_FALSE = 5'd4;
  localparam logic [KIND_W-1:0] KIND_IF    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_ELSE  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_WORD  = 5'd7;
  localparam logic [KIND_W-1:0] KIND_PLUS  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_NL    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_MINUS = 5'd10;
  localparam logic [KIND_W-1:0] KIND_STAR  = 5'd11;
  localparam logic [KIND_W-1:0] KIND_SLASH = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LPAR  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RPAR  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_COMMA = 5'd15;
  localparam logic [KIND_W-1:0] KIND_SEMI  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LBRC  = 5'd17;
  localparam logic [KIND_W-1:0] KIND_RBRC  = 5'd18;
  localparam logic [KIND_W-1:0] KIND_BSL   = 5'd19;
  localparam logic [KIND_W-1:0] KIND_ERR   = 5'd20;
  localparam logic [KIND_W-1:0] KIND_EOF   = 5'd21;

  localparam logic [PLACES_W-1:0] MAX_PLACES = 4'd15;

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_DIGIT,
    CL_WORD,
    CL_EQ,
    CL_DOT,
    CL_OTHER,
    CL_EOF
  } char_class_t;

  typedef struct packed {
    char_class_t       cls;
    logic [7:0]        ch;
    logic [KIND_W-1:0] skind;
  } q_item_t;

  // Token kind of a character that stands alone; unknown bytes give an error.
  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] ch);
    logic [KIND_W-1:0] k;
    begin
      case (ch)
        8'h2B:   k = KIND_PLUS;
        8'h0A:   k = KIND_NL;
        8'h2D:   k = KIND_MINUS;
        8'h2A:   k = KIND_STAR;
        8'h2F:   k = KIND_SLASH;
        8'h28:   k = KIND_LPAR;
        8'h29:   k = KIND_RPAR;
        8'h2C:   k = KIND_COMMA;
        8'h3B:   k = KIND_SEMI;
        8'h7B:   k = KIND_LBRC;
        8'h7D:   k = KIND_RBRC;
        8'h5C:   k = KIND_BSL;
        8'h3F:   k = KIND_IF;
        8'h3A:   k = KIND_ELSE;
        default: k = KIND_ERR;
      endcase
      return k;
    end
  endfunction

  // Keywords in priority order: TRUE, T, FALSE, F, if, else.
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] l;
    begin
      case (k)
        3'd0:    l = 3'd4;
        3'd1:    l = 3'd1;
        3'd2:    l = 3'd5;
        3'd3:    l = 3'd1;
        3'd4:    l = 3'd2;
        3'd5:    l = 3'd4;
        default: l = 3'd0;
      endcase
      return l;
    end
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [2:0] k);
    logic [KIND_W-1:0] r;
    begin
      case (k)
        3'd0, 3'd1: r = KIND_TRUE;
        3'd2, 3'd3: r = KIND_FALSE;
        3'd4:       r = KIND_IF;
        3'd5:       r = KIND_ELSE;
        default:    r = KIND_WORD;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
    logic [7:0] c;
    begin
      c = 8'h00;
      case (k)
        3'd0, 3'd1: begin
          case (idx)
            3'd0:    c = 8'h54; // T
            3'd1:    c = 8'h52; // R
            3'd2:    c = 8'h55; // U
            3'd3:    c = 8'h45; // E
            default: c = 8'h00;
          endcase
        end
        3'd2, 3'd3: begin
          case (idx)
            3'd0:    c = 8'h46; // F
            3'd1:    c = 8'h41; // A
            3'd2:    c = 8'h4C; // L
            3'd3:    c = 8'h53; // S
            3'd4:    c = 8'h45; // E
            default: c = 8'h00;
          endcase
        end
        3'd4: begin
          case (idx)
            3'd0:    c = 8'h69; // i
            3'd1:    c = 8'h66; // f
            default: c = 8'h00;
          endcase
        end
        3'd5: begin
          case (idx)
            3'd0:    c = 8'h65; // e
            3'd1:    c = 8'h6C; // l
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h65; // e
            default: c = 8'h00;
          endcase
        end
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

@@ design/exptok_front.sv @@
// ----------------------------------------------------------------------------
// exptok_front: input side classifier
// Takes source bytes, sorts each into a character class and writes it into
// the queue in front of the lexer.
// ----------------------------------------------------------------------------
module exptok_front
  import exptok_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output q_item_t    q_item
);

  logic [7:0] ch;

  assign ch        = in_tdata;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.ch    = ch;
    q_item.skind = single_kind(ch);
    if (in_tlast) begin
      q_item.cls = CL_EOF;
    end else if (ch == 8'h20 || ch == 8'h09) begin
      q_item.cls = CL_SPACE;
    end else if (ch inside {[8'h30:8'h39]}) begin
      q_item.cls = CL_DIGIT;
    end else if (ch inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
      q_item.cls = CL_WORD;
    end else if (ch == 8'h3D) begin
      q_item.cls = CL_EQ;
    end else if (ch == 8'h2E) begin
      q_item.cls = CL_DOT;
    end else begin
      q_item.cls = CL_OTHER;
    end
  end

endmodule

@@ design/exptok_queue.sv @@
// ----------------------------------------------------------------------------
// exptok_queue: classified character queue
// Small first-in first-out buffer between classifier and lexer.
// ----------------------------------------------------------------------------
module exptok_queue
  import exptok_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  q_item_t wr_item,
  output logic    full,
  input  logic    rd_en,
  output logic    rd_valid,
  output q_item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ design/exptok_back.sv @@
// ----------------------------------------------------------------------------
// exptok_back: lexer core and token buffer
// Pops classified characters, runs the lexing state machine and places up to
// two tokens per character in a three-entry token buffer whose head is the
// output register.
// ----------------------------------------------------------------------------
module exptok_back
  import exptok_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  q_item_t                  q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic [MANTISSA_BITS-1:0] out_mant,
  output logic [PLACES_W-1:0]      out_places,
  output logic                     out_sat,
  output logic [LENGTH_BITS-1:0]   out_len,
  output logic                     out_last
);

  localparam int MB        = MANTISSA_BITS;
  localparam int LB        = LENGTH_BITS;
  localparam int TOK_SLOTS = 3;

  typedef enum logic [2:0] {
    M_IDLE,
    M_INT,
    M_FRAC,
    M_WORD,
    M_EQ
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [MB-1:0]       mant;
    logic [PLACES_W-1:0] places;
    logic                sat;
    logic [LB-1:0]       len;
    logic                last;
  } tok_t;

  mode_t                mode_r,    mode_nxt;
  logic [MB-1:0]        mant_r,    mant_nxt;
  logic [PLACES_W-1:0]  places_r,  places_nxt;
  logic                 ovf_r,     ovf_nxt;
  logic [LB-1:0]        run_r,     run_nxt;
  logic [NUM_KW-1:0]    cand_r,    cand_nxt;
  tok_t [TOK_SLOTS-1:0] tbuf_r,    tbuf_nxt;
  logic [1:0]           tcnt_r,    tcnt_nxt;
  tok_t [TOK_SLOTS-1:0] hold_buf;
  logic [1:0]           hold_cnt;

  // step results for the head character
  mode_t               s_mode;
  logic [MB-1:0]       s_mant;
  logic [PLACES_W-1:0] s_places;
  logic                s_ovf;
  logic [LB-1:0]       s_run;
  logic [NUM_KW-1:0]   s_cand;
  tok_t                res0, res1;
  logic                res0_v, res1_v;

  logic [MB+3:0]       wide;
  logic                fits;
  logic [NUM_KW-1:0]   wc_cand, st_cand;
  logic [LB-1:0]       run_inc;
  logic [KIND_W-1:0]   word_kind;
  tok_t                fl_tok, st_tok, sec_tok;
  logic                st_v, sec_v, do_flush, fl_v, slot_free;
  mode_t               st_mode;
  logic [MB-1:0]       st_mant;
  logic [LB-1:0]       st_run;

  // mantissa * 10 + digit, overflow when the top bits are set
  assign wide = ({4'b0, mant_r} << 3) + ({4'b0, mant_r} << 1) + (MB+4)'(q_item.ch[3:0]);
  assign fits = (wide[MB+3:MB] == 4'b0);
  assign run_inc = (run_r == '1) ? run_r : run_r + LB'(1);

  // keyword candidate update: continuing run and fresh run
  always_comb begin
    wc_cand = cand_r;
    st_cand = '1;
    for (int k = 0; k < NUM_KW; k++) begin
      if (run_r >= LB'(kw_len(3'(k))) || kw_char(3'(k), run_r[2:0]) != q_item.ch) begin
        wc_cand[k] = 1'b0;
      end
      if (kw_char(3'(k), 3'd0) != q_item.ch) begin
        st_cand[k] = 1'b0;
      end
    end
  end

  // first keyword in priority order that matches completely
  always_comb begin
    word_kind = KIND_WORD;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand_r[k] && run_r == LB'(kw_len(3'(k)))) begin
        word_kind = kw_kind(3'(k));
      end
    end
  end

  // token for the run that is open
  always_comb begin
    fl_tok = '0;
    fl_v   = 1'b0;
    case (mode_r)
      M_INT, M_FRAC: begin
        fl_v          = 1'b1;
        fl_tok.kind   = KIND_NUM;
        fl_tok.mant   = mant_r;
        fl_tok.places = places_r;
        fl_tok.sat    = ovf_r;
      end
      M_WORD: begin
        fl_v        = 1'b1;
        fl_tok.kind = word_kind;
        fl_tok.len  = run_r;
      end
      M_EQ: begin
        fl_v        = 1'b1;
        fl_tok.kind = (run_r == LB'(1)) ? KIND_EQ :
                      (run_r == LB'(2)) ? KIND_DEQ : KIND_ERR;
        fl_tok.len  = run_r;
      end
      default: fl_v = 1'b0;
    endcase
  end

  // character seen from a cleared state
  always_comb begin
    st_mode     = M_IDLE;
    st_mant     = '0;
    st_run      = '0;
    st_v        = 1'b0;
    st_tok      = '0;
    st_tok.kind = q_item.skind;
    case (q_item.cls)
      CL_SPACE: st_mode = M_IDLE;
      CL_DIGIT: begin
        st_mode = M_INT;
        st_mant = MB'(q_item.ch[3:0]);
      end
      CL_WORD: begin
        st_mode = M_WORD;
        st_run  = LB'(1);
      end
      CL_EQ: begin
        st_mode = M_EQ;
        st_run  = LB'(1);
      end
      default: st_v = 1'b1;
    endcase
  end

  // one lexing step
  always_comb begin
    s_mode   = mode_r;
    s_mant   = mant_r;
    s_places = places_r;
    s_ovf    = ovf_r;
    s_run    = run_r;
    s_cand   = cand_r;
    do_flush = 1'b0;
    sec_v    = 1'b0;
    sec_tok  = st_tok;
    if (q_item.cls == CL_EOF) begin
      do_flush     = 1'b1;
      sec_v        = 1'b1;
      sec_tok      = '0;
      sec_tok.kind = KIND_EOF;
      s_mode       = M_IDLE;
      s_mant       = '0;
      s_places     = '0;
      s_ovf        = 1'b0;
      s_run        = '0;
      s_cand       = '1;
    end else begin
      case (mode_r)
        M_INT: begin
          if (q_item.cls == CL_DIGIT) begin
            if (fits) begin
              s_mant = wide[MB-1:0];
            end else begin
              s_mant = '1;
              s_ovf  = 1'b1;
            end
          end else if (q_item.cls == CL_DOT) begin
            s_mode = M_FRAC;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_FRAC: begin
          if (q_item.cls == CL_DIGIT) begin
            if (places_r != MAX_PLACES && fits) begin
              s_mant   = wide[MB-1:0];
              s_places = places_r + PLACES_W'(1);
            end else begin
              s_ovf = 1'b1;
            end
          end else begin
            do_flush = 1'b1;
          end
        end
        M_WORD: begin
          if (q_item.cls == CL_WORD) begin
            s_cand = wc_cand;
            s_run  = run_inc;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_EQ: begin
          if (q_item.cls == CL_EQ) begin
            s_run = run_inc;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: do_flush = 1'b1;
      endcase
      if (do_flush) begin
        sec_v    = st_v;
        s_mode   = st_mode;
        s_mant   = st_mant;
        s_places = '0;
        s_ovf    = 1'b0;
        s_run    = st_run;
        s_cand   = (q_item.cls == CL_WORD) ? st_cand : '1;
      end
    end
  end

  always_comb begin
    res0_v    = (do_flush && fl_v) || sec_v;
    res1_v    = do_flush && fl_v && sec_v;
    res0      = (do_flush && fl_v) ? fl_tok : sec_tok;
    res0.last = !res1_v;
    res1      = sec_tok;
    res1.last = 1'b1;
  end

  // tokens still held once this cycle's output transfer has gone
  always_comb begin
    hold_buf = tbuf_r;
    hold_cnt = tcnt_r;
    if (tcnt_r != 2'd0 && out_ready) begin
      hold_buf[0] = tbuf_r[1];
      hold_buf[1] = tbuf_r[2];
      hold_cnt    = tcnt_r - 2'd1;
    end
  end

  // a character is taken only when both of its possible tokens have room
  assign slot_free = (hold_cnt <= 2'd1);

  always_comb begin
    mode_nxt   = mode_r;
    mant_nxt   = mant_r;
    places_nxt = places_r;
    ovf_nxt    = ovf_r;
    run_nxt    = run_r;
    cand_nxt   = cand_r;
    tbuf_nxt   = hold_buf;
    tcnt_nxt   = hold_cnt;
    q_pop      = 1'b0;
    if (q_valid && slot_free) begin
      q_pop      = 1'b1;
      mode_nxt   = s_mode;
      mant_nxt   = s_mant;
      places_nxt = s_places;
      ovf_nxt    = s_ovf;
      run_nxt    = s_run;
      cand_nxt   = s_cand;
      if (res0_v) begin
        tbuf_nxt[hold_cnt] = res0;
        tcnt_nxt           = hold_cnt + 2'd1;
      end
      if (res1_v) begin
        tbuf_nxt[hold_cnt + 2'd1] = res1;
        tcnt_nxt                  = hold_cnt + 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      mant_r   <= '0;
      places_r <= '0;
      ovf_r    <= 1'b0;
      run_r    <= '0;
      cand_r   <= '1;
      tcnt_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      mant_r   <= mant_nxt;
      places_r <= places_nxt;
      ovf_r    <= ovf_nxt;
      run_r    <= run_nxt;
      cand_r   <= cand_nxt;
      tcnt_r   <= tcnt_nxt;
    end
    tbuf_r <= tbuf_nxt;
  end

  assign out_valid  = (tcnt_r != 2'd0);
  assign out_kind   = tbuf_r[0].kind;
  assign out_mant   = tbuf_r[0].mant;
  assign out_places = tbuf_r[0].places;
  assign out_sat    = tbuf_r[0].sat;
  assign out_len    = tbuf_r[0].len;
  assign out_last   = tbuf_r[0].last;

endmodule

@@ design/expression_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// expression_tokenizer_top: character-serial expression tokenizer
// One source byte in per transfer, tokens out per transfer.
// ----------------------------------------------------------------------------
// Usage: feed source text one byte per input transfer; a transfer with in_tlast
// high ends the text (its byte is ignored), flushes any open token and gives
// an EOF token, after which a new text may start. Spaces and tabs are dropped.
// Numbers come out as mantissa plus count of fraction digits
// (value = mantissa / 10^places), saturating with a flag. Words, keywords and
// '=' runs carry their length. Each input transfer causes zero, one or two
// tokens; out_tlast marks the last token caused by a given input byte.
// Rate: one byte per clock, sustained. The lexer takes one classified byte a
// cycle and puts its tokens into a three-entry token buffer whose head drives
// the output; it takes a byte whenever two entries will be free after the
// current output transfer. A byte that gives two tokens leaves the lexer idle,
// so the next one gives at most one, and tokens never average more than one
// per byte: with out_tready high the buffer never holds the lexer up. The
// classified-character queue (QUEUE_DEPTH entries) takes up receiver stalls.
// A byte is written into the queue at its input transfer; the lexer step then
// pops it and writes its first token into the token buffer, whose head is the
// output register. The lexer state update is one shift-add of the mantissa
// and a compare per cycle.
// ----------------------------------------------------------------------------
module expression_tokenizer_top
  import exptok_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  localparam int OUT_W = ((MANTISSA_BITS + PLACES_W + 1 + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // source bytes
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              in_tlast,   // end_of_input
  // tokens
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // number_mantissa, fraction_places,
                                        // number_saturated, text_length, zero pad
  output logic [KIND_W-1:0] out_tuser,  // token_kind
  output logic              out_tlast   // last_of_item
);

  logic                     q_full, q_push, q_pop, q_valid;
  q_item_t                  q_wr_item, q_rd_item;
  logic [MANTISSA_BITS-1:0] tok_mant;
  logic [PLACES_W-1:0]      tok_places;
  logic                     tok_sat;
  logic [LENGTH_BITS-1:0]   tok_len;

  // front: classify and enqueue
  exptok_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  // decoupling queue
  exptok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  // back: lexer and token buffer
  exptok_back #(
    .MANTISSA_BITS (MANTISSA_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_mant   (tok_mant),
    .out_places (tok_places),
    .out_sat    (tok_sat),
    .out_len    (tok_len),
    .out_last   (out_tlast)
  );

  // fields packed from bit 0 up, zero padded to whole bytes
  assign out_tdata = OUT_W'({tok_len, tok_sat, tok_places, tok_mant});

  // EOF always closes the tokens of its input byte
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EOF |-> out_tlast)
    else $error("EOF token without last marker");

  // only number tokens carry number fields
  a_num_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_NUM |->
      tok_mant == '0 && tok_places == '0 && !tok_sat)
    else $error("number fields set on a non-number token");

  // lexer never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
